// ===== src/c2p_pkg.sv =====
// Package for the conserved-to-primitive converter: widths, register
// indexes and the item structs. No dependencies.
package c2p_pkg;

  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;
  localparam int GAM_W  = 17;
  localparam int FLR_W  = 31;
  localparam int QUO_W  = 32;
  localparam int VDVD_W = DATA_W + FRAC_W;
  localparam int KDVD_W = 2 * DATA_W;
  localparam int RDVD_W = FLR_W + FRAC_W;
  localparam int DIV_LAT = QUO_W + 1;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_GAMMA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DFLR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PFLR  = 2'd2;

  localparam logic [GAM_W-1:0] GAMMA_RST = 17'd43691;
  localparam logic [FLR_W-1:0] DFLR_RST  = 31'd1;
  localparam logic [FLR_W-1:0] PFLR_RST  = 31'd1;

  typedef struct packed {
    logic signed [DATA_W-1:0] density;
    logic signed [DATA_W-1:0] momentum_x;
    logic signed [DATA_W-1:0] momentum_y;
    logic signed [DATA_W-1:0] momentum_z;
    logic signed [DATA_W-1:0] total_energy;
  } in_item_t;

  typedef struct packed {
    logic        [FLR_W-1:0]  density_out;
    logic signed [DATA_W-1:0] velocity_x;
    logic signed [DATA_W-1:0] velocity_y;
    logic signed [DATA_W-1:0] velocity_z;
    logic        [FLR_W-1:0]  pressure;
    logic signed [DATA_W-1:0] energy_out;
  } out_item_t;

endpackage

// ===== src/c2p_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, flags a quotient
// that does not fit QUO_W bits. Depends on c2p_pkg.
module c2p_div #(
  parameter int DVD_W = 48,
  parameter int DVS_W = 31
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic [DVD_W-1:0]                dvd_i,
  input  logic [DVS_W-1:0]                dvs_i,
  output logic [c2p_pkg::QUO_W-1:0]       quot_o,
  output logic                            ovf_o
);
  import c2p_pkg::*;

  localparam int HI_W = DVD_W - QUO_W;
  localparam int CW   = (HI_W > DVS_W) ? HI_W : DVS_W;

  logic [DVS_W-1:0] rem_r  [0:QUO_W];
  logic [QUO_W-1:0] lo_r   [0:QUO_W];
  logic [QUO_W-1:0] quot_r [0:QUO_W];
  logic [DVS_W-1:0] dvs_r  [0:QUO_W];
  logic             ovf_r  [0:QUO_W];

  logic [DVS_W-1:0] rem_nxt  [0:QUO_W-1];
  logic [QUO_W-1:0] quot_nxt [0:QUO_W-1];

  logic [HI_W-1:0] hi;
  assign hi = dvd_i[DVD_W-1:QUO_W];

  always_comb begin
    logic [DVS_W:0] trial;
    logic           ge;
    for (int k = 0; k < QUO_W; k++) begin
      trial = {rem_r[k], lo_r[k][QUO_W-1]};
      ge = trial >= {1'b0, dvs_r[k]};
      rem_nxt[k] = ge ? DVS_W'(trial - {1'b0, dvs_r[k]}) : trial[DVS_W-1:0];
      quot_nxt[k] = {quot_r[k][QUO_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= DVS_W'(hi);
      lo_r[0]   <= dvd_i[QUO_W-1:0];
      quot_r[0] <= '0;
      dvs_r[0]  <= dvs_i;
      ovf_r[0]  <= CW'(hi) >= CW'(dvs_i);
      for (int k = 0; k < QUO_W; k++) begin
        rem_r[k+1]  <= rem_nxt[k];
        lo_r[k+1]   <= {lo_r[k][QUO_W-2:0], 1'b0};
        quot_r[k+1] <= quot_nxt[k];
        dvs_r[k+1]  <= dvs_r[k];
        ovf_r[k+1]  <= ovf_r[k];
      end
    end
  end

  assign quot_o = quot_r[QUO_W];
  assign ovf_o  = ovf_r[QUO_W];

endmodule

// ===== src/conserved_to_primitive_adiabatic.sv =====
// Conserved-to-primitive conversion for adiabatic Euler, Q16.16.
// 38 register stages; throughput one item per cycle while in_ready is high (a stalled output
// or a busy floor-quotient unit holds it low); the 33-stage divider pipelines (one quotient
// bit a stage) set the depth.
// Reset (synchronous, active low) loads register defaults; after reset and after
// every config write, in_ready stays low while the bit-serial unit forms
// pressure_floor/gamma_minus_one for the energy correction.
module conserved_to_primitive_adiabatic (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  c2p_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output c2p_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [c2p_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [c2p_pkg::DATA_W-1:0]    cfg_data
);
  import c2p_pkg::*;

  localparam logic [DATA_W-1:0] POS_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] NEG_MAG = {1'b1, {(DATA_W-1){1'b0}}};
  localparam int PROD_W = GAM_W + FLR_W;
  localparam int CNT_W  = $clog2(RDVD_W + 1);

  typedef struct packed {
    logic [FLR_W-1:0]         dd;
    logic [2:0]               neg;
    logic signed [DATA_W-1:0] e;
  } side_t;

  // ---------------- configuration registers ----------------
  logic [GAM_W-1:0] gam_r;
  logic [FLR_W-1:0] dfl_r, pfl_r;
  logic             cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gam_r <= GAMMA_RST;
      dfl_r <= DFLR_RST;
      pfl_r <= PFLR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GAMMA: gam_r <= cfg_data[GAM_W-1:0];
        CFG_DFLR:  dfl_r <= cfg_data[FLR_W-1:0];
        CFG_PFLR:  pfl_r <= cfg_data[FLR_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- floor energy quotient: (pfl << F) / (gamma - 1) ----------------
  // Bit-serial restoring divide; dividend shifts out, quotient shifts in.
  logic                restart_r, busy_r;
  logic [CNT_W-1:0]    rcnt_r;
  logic [RDVD_W-1:0]   rdvd_r;
  logic [GAM_W-1:0]    rrem_r, rdvs_r;
  logic [DATA_W-1:0]   qc_r;
  logic [GAM_W:0]      rtrial;
  logic                rge;

  assign rtrial = {rrem_r, rdvd_r[RDVD_W-1]};
  assign rge    = rtrial >= {1'b0, rdvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      restart_r <= 1'b1;
      busy_r    <= 1'b0;
      rcnt_r    <= '0;
    end else if (cfg_we) begin
      restart_r <= 1'b1;
      busy_r    <= 1'b0;
    end else if (restart_r) begin
      restart_r <= 1'b0;
      busy_r    <= 1'b1;
      rcnt_r    <= CNT_W'(RDVD_W);
    end else if (busy_r) begin
      rcnt_r <= rcnt_r - 1'b1;
      if (rcnt_r == CNT_W'(1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (restart_r) begin
      rdvd_r <= {pfl_r, {FRAC_W{1'b0}}};
      rrem_r <= '0;
      rdvs_r <= (gam_r == '0) ? GAM_W'(1) : gam_r;
    end else if (busy_r) begin
      rdvd_r <= {rdvd_r[RDVD_W-2:0], rge};
      rrem_r <= rge ? GAM_W'(rtrial - {1'b0, rdvs_r}) : rtrial[GAM_W-1:0];
      if (rcnt_r == CNT_W'(1)) begin
        // quotient at or above 2^31 only ever saturates the energy
        qc_r <= (|rdvd_r[RDVD_W-2:DATA_W-2])
                ? NEG_MAG : {1'b0, rdvd_r[DATA_W-3:0], rge};
      end
    end
  end

  // ---------------- pipeline control ----------------
  logic out_vld_r, en;
  assign en       = !out_vld_r || out_ready;
  assign in_ready = en && !restart_r && !busy_r;

  // ---------------- S1: density floor, magnitudes ----------------
  logic [FLR_W-1:0]  dfl_eff, dd_in;
  logic [DATA_W-1:0] mag_in [0:2];
  logic [2:0]        neg_in;
  logic signed [DATA_W-1:0] mom_in [0:2];

  assign dfl_eff = (dfl_r == '0) ? FLR_W'(1) : dfl_r;
  assign dd_in   = (in_data.density > $signed({1'b0, dfl_eff}))
                   ? in_data.density[FLR_W-1:0] : dfl_eff;
  assign mom_in[0] = in_data.momentum_x;
  assign mom_in[1] = in_data.momentum_y;
  assign mom_in[2] = in_data.momentum_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_in[i] = mom_in[i][DATA_W-1];
      mag_in[i] = neg_in[i] ? DATA_W'(-mom_in[i]) : mom_in[i];
    end
  end

  logic              s1_vld_r, s2_vld_r, s3_vld_r;
  side_t             s1_side_r, s2_side_r, s3_side_r;
  logic [DATA_W-1:0] s1_mag_r [0:2];
  logic [DATA_W-1:0] s2_mag_r [0:2];
  logic [KDVD_W-1:0] s2_sq_r  [0:2];
  logic [VDVD_W-1:0] s3_vdvd_r [0:2];
  logic [KDVD_W-1:0] s3_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_valid && in_ready;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  // S1 -> S2: squares; S2 -> S3: sum of squares
  always_ff @(posedge clk) begin
    if (en) begin
      s1_side_r <= '{dd: dd_in, neg: neg_in, e: in_data.total_energy};
      s2_side_r <= s1_side_r;
      s3_side_r <= s2_side_r;
      for (int i = 0; i < 3; i++) begin
        s1_mag_r[i]  <= mag_in[i];
        s2_mag_r[i]  <= s1_mag_r[i];
        s2_sq_r[i]   <= s1_mag_r[i] * s1_mag_r[i];
        s3_vdvd_r[i] <= {s2_mag_r[i], {FRAC_W{1'b0}}};
      end
      s3_sum_r <= s2_sq_r[0] + s2_sq_r[1] + s2_sq_r[2];
    end
  end

  // ---------------- divider stages ----------------
  logic [QUO_W-1:0] vq [0:2];
  logic [2:0]       vovf;
  logic [QUO_W-1:0] kq;
  logic             kovf;

  for (genvar i = 0; i < 3; i++) begin : g_vdiv
    c2p_div #(.DVD_W(VDVD_W), .DVS_W(FLR_W)) u_vdiv (
      .clk   (clk),
      .en    (en),
      .dvd_i (s3_vdvd_r[i]),
      .dvs_i (s3_side_r.dd),
      .quot_o(vq[i]),
      .ovf_o (vovf[i])
    );
  end

  c2p_div #(.DVD_W(KDVD_W), .DVS_W(DATA_W)) u_kdiv (
    .clk   (clk),
    .en    (en),
    .dvd_i (s3_sum_r),
    .dvs_i ({s3_side_r.dd, 1'b0}),
    .quot_o(kq),
    .ovf_o (kovf)
  );

  // sidecar shift line alongside the dividers
  logic  dv_vld_r  [0:DIV_LAT-1];
  side_t dv_side_r [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_LAT; k++) dv_vld_r[k] <= 1'b0;
    end else if (en) begin
      dv_vld_r[0] <= s3_vld_r;
      for (int k = 1; k < DIV_LAT; k++) dv_vld_r[k] <= dv_vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_side_r[0] <= s3_side_r;
      for (int k = 1; k < DIV_LAT; k++) dv_side_r[k] <= dv_side_r[k-1];
    end
  end

  // ---------------- P1: saturate velocities, kinetic energy, gamma product ----------------
  function automatic logic [DATA_W-1:0] sat_vel(input logic neg, input logic ovf,
                                                input logic [QUO_W-1:0] q);
    logic [DATA_W-1:0] r;
    if (neg) r = (ovf || q > NEG_MAG) ? NEG_MAG : DATA_W'(-q);
    else     r = (ovf || q > POS_MAX) ? POS_MAX : q;
    return r;
  endfunction

  side_t             dv_side;
  logic [DATA_W-1:0] ekc;
  logic              gtr;
  logic [FLR_W-1:0]  diff;

  assign dv_side = dv_side_r[DIV_LAT-1];
  // kinetic energy at or above 2^31 behaves the same as exactly 2^31
  assign ekc  = (kovf || kq[QUO_W-1]) ? NEG_MAG : kq;
  assign gtr  = !dv_side.e[DATA_W-1] && ({1'b0, dv_side.e[DATA_W-2:0]} > ekc);
  assign diff = dv_side.e[FLR_W-1:0] - ekc[FLR_W-1:0];

  logic              p1_vld_r, p1_gtr_r;
  logic [DATA_W-1:0] p1_vel_r [0:2];
  logic [FLR_W-1:0]  p1_dd_r;
  logic signed [DATA_W-1:0] p1_e_r;
  logic [DATA_W-1:0] p1_ek_r;
  logic [PROD_W-1:0] p1_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) p1_vld_r <= 1'b0;
    else if (en) p1_vld_r <= dv_vld_r[DIV_LAT-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++)
        p1_vel_r[i] <= sat_vel(dv_side.neg[i], vovf[i], vq[i]);
      p1_dd_r   <= dv_side.dd;
      p1_e_r    <= dv_side.e;
      p1_ek_r   <= ekc;
      p1_gtr_r  <= gtr;
      p1_prod_r <= gam_r * diff;
    end
  end

  // ---------------- output stage: pressure floor and energy correction ----------------
  logic [DATA_W-1:0] praw;
  logic              floored;
  logic [DATA_W:0]   corr;
  out_item_t         out_nxt;
  out_item_t         out_r;

  assign praw    = p1_prod_r[FRAC_W +: DATA_W];
  assign floored = !p1_gtr_r || !(praw > {1'b0, pfl_r});
  assign corr    = {1'b0, qc_r} + {1'b0, p1_ek_r};

  always_comb begin
    out_nxt.density_out = p1_dd_r;
    out_nxt.velocity_x  = p1_vel_r[0];
    out_nxt.velocity_y  = p1_vel_r[1];
    out_nxt.velocity_z  = p1_vel_r[2];
    if (floored) begin
      out_nxt.pressure   = pfl_r;
      out_nxt.energy_out = (corr > {1'b0, POS_MAX}) ? POS_MAX : corr[DATA_W-1:0];
    end else begin
      out_nxt.pressure   = praw[DATA_W-1] ? POS_MAX[FLR_W-1:0] : praw[FLR_W-1:0];
      out_nxt.energy_out = p1_e_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (en) out_vld_r <= p1_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) out_r <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  // no item enters while the floor-energy quotient is stale
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (restart_r || busy_r) |-> !in_ready)
    else $error("item accepted while floor quotient is being formed");

  // a new result appears only from a valid item in the P1 stage
  a_out_from_p1: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_vld_r ##1 out_vld_r) |-> $past(p1_vld_r))
    else $error("result valid without a source item");

  // a stalled output holds the pipeline still
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_ready) |=> $stable(p1_vld_r) && $stable(dv_vld_r[DIV_LAT-1]))
    else $error("pipeline moved under a stalled result");
`endif

endmodule
